// ===== rtl/core/fp64sc_pkg.sv =====
`timescale 1ns / 1ps
package fp64sc_pkg;
  localparam int FRAC_W = 52;
  localparam int EXP_W = 11;
  localparam int N_W = 32;
  localparam int E_W = 34;
  localparam logic [10:0] EXP_ALL = 11'h7ff;
  localparam logic signed [E_W-1:0] MAX_BEXP = 34'sd2046;
  localparam logic signed [E_W-1:0] MIN_SPAN = -34'sd53;

  typedef struct packed {
    logic        sign;
    logic [51:0] frac;
    logic signed [E_W-1:0] e;
    logic        special;
    logic [63:0] special_bits;
    logic        special_inv;
  } stage_t;

  typedef struct packed {
    logic [63:0] bits;
    logic inv;
    logic ovf;
    logic unf;
    logic inx;
  } result_t;
endpackage

// ===== rtl/core/fp64sc_unpack.sv =====
`timescale 1ns / 1ps
module fp64sc_unpack (
  input  logic [63:0]              x_bits,
  input  logic signed [31:0]       scale_exponent,
  output fp64sc_pkg::stage_t       stg
);
  logic [62:0] mag;
  logic [5:0]  lz;
  logic [52:0] nsig;
  logic        is_nan_inf, is_snan;

  always_comb begin
    mag = x_bits[62:0];
    // Normalising shift for a subnormal: moves the leading one of the fraction into the hidden-bit position.
    lz = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (x_bits[i]) lz = 6'(52 - i);
    end
    nsig = {1'b0, x_bits[51:0]} << lz;
    is_nan_inf = (x_bits[62:52] == fp64sc_pkg::EXP_ALL);
    is_snan = is_nan_inf && (x_bits[51:0] != 52'd0) && !x_bits[51];
    stg.sign = x_bits[63];
    stg.special_inv = is_snan;
    stg.special_bits = is_snan ? (x_bits | 64'h0008000000000000) : x_bits;
    stg.special = is_nan_inf || (mag == 63'd0) || (scale_exponent == 32'sd0);
    if (x_bits[62:52] == 11'd0) begin
      stg.frac = nsig[51:0];
      stg.e = 34'(signed'({1'b0, 6'd1})) - 34'(signed'({1'b0, lz}))
              + 34'(scale_exponent);
    end else begin
      stg.frac = x_bits[51:0];
      stg.e = 34'(signed'({1'b0, x_bits[62:52]})) + 34'(scale_exponent);
    end
  end
endmodule

// ===== rtl/core/fp64sc_round.sv =====
`timescale 1ns / 1ps
module fp64sc_round (
  input  fp64sc_pkg::stage_t  stg,
  output fp64sc_pkg::result_t res
);
  logic [52:0]  sig;
  logic [5:0]   sh;
  logic [105:0] wide;
  logic [52:0]  kept, rem, half;
  logic         lost, up;

  always_comb begin
    sig = {1'b1, stg.frac};
    sh = 6'(34'sd1 - stg.e);
    wide = {sig, 53'd0} >> sh;
    kept = wide[105:53];
    rem = wide[52:0];
    half = {1'b1, 52'd0};
    lost = rem != 53'd0;
    up = (rem > half) || (rem == half && kept[0]);
    res = '0;
    if (stg.special) begin
      res.bits = stg.special_bits;
      res.inv = stg.special_inv;
    end else if (stg.e > fp64sc_pkg::MAX_BEXP) begin
      res.bits = {stg.sign, fp64sc_pkg::EXP_ALL, 52'd0};
      res.ovf = 1'b1;
      res.inx = 1'b1;
    end else if (stg.e <= fp64sc_pkg::MIN_SPAN) begin
      res.bits = {stg.sign, 63'd0};
      res.unf = 1'b1;
      res.inx = 1'b1;
    end else if (stg.e >= 34'sd1) begin
      res.bits = {stg.sign, stg.e[10:0], stg.frac};
    end else begin
      res.bits = {stg.sign, 10'd0, kept + 53'(up)};
      res.unf = lost;
      res.inx = lost;
    end
  end
endmodule

// ===== rtl/core/fp64_scale_by_power_of_two_top.sv =====
`timescale 1ns / 1ps
// Binary64 ldexp: result = x * 2^n with IEEE exception flags.
// Input beat on s_axis: tdata holds x_bits then scale_exponent.
// Output beat on m_axis: tdata holds result_bits, tuser the four flags.
// Pipeline: an input register, decode and normalise logic, then the
// exponent check and subnormal rounding feeding an output register.
// An accepted beat is held in the input register, then in the output register that drives m_axis.
// Throughput is one beat per cycle; the pipeline advances whenever the
// output register is empty or being taken, so a stalled receiver holds
// both stages and deasserts s_axis_tready only when both are full.
// Reset (rst, synchronous) empties both stages; no beat is lost or
// repeated when m_axis_tready falls.
// The subnormal path uses a 106-bit right shift by up to 53 places,
// which sets the depth of the second stage.
module fp64_scale_by_power_of_two_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // x_bits[63:0], scale_exponent[95:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // result_bits[63:0]
  output logic [7:0]   m_axis_tuser   // invalid, overflow, underflow, inexact, zeros
);
  logic [95:0] in_reg;
  logic in_vld, out_vld, adv;
  fp64sc_pkg::stage_t  stg;
  fp64sc_pkg::result_t res, out_reg;

  assign adv = !out_vld || m_axis_tready;
  assign s_axis_tready = adv || !in_vld;

  fp64sc_unpack u_unpack (
    .x_bits(in_reg[63:0]), .scale_exponent(signed'(in_reg[95:64])), .stg(stg));
  fp64sc_round u_round (.stg(stg), .res(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (adv) begin
        out_vld <= in_vld;
        if (in_vld) out_reg <= res;
      end
      if (s_axis_tready) begin
        in_vld <= s_axis_tvalid;
        if (s_axis_tvalid) in_reg <= s_axis_tdata;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata = out_reg.bits;
  assign m_axis_tuser = {4'd0, out_reg.inx, out_reg.unf, out_reg.ovf, out_reg.inv};
endmodule

// ===== rtl/core/fp64sc_checker.sv =====
`timescale 1ns / 1ps
module fp64sc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped while stalled");
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[62:0] == 63'h7ff0000000000000
      && m_axis_tuser[3])
    else $error("overflow without infinity");
  a_unf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[3] && m_axis_tdata[62:52] <= 11'd1)
    else $error("underflow on normal result");
  a_inv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[62:51] == 12'hfff
      && m_axis_tuser[3:1] == 3'd0)
    else $error("invalid without quiet NaN");
endmodule

bind fp64_scale_by_power_of_two_top fp64sc_checker u_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));
